// ----- design/sha_pkg.sv -----
// ----------------------------------------------------------------------------
// sha_pkg
// shared types, constants and round functions of the sha-256 digest engine
// ----------------------------------------------------------------------------
package sha_pkg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD,
        ST_LOAD,
        ST_ROUND,
        ST_FINAL,
        ST_OUT
    } state_t;

    localparam logic [7:0] PAD_BYTE = 8'h80;

    typedef logic [31:0] word_t;

    // memory access from the controller to the block buffer
    typedef struct packed {
        logic       wr_en;
        logic [3:0] wr_addr;
        word_t      wr_data;
        logic [3:0] rd_addr;
    } buf_req_t;

    function automatic word_t init_hash(input logic [2:0] idx);
        word_t r;
        case (idx)
            3'd0: r = 32'h6a09e667;
            3'd1: r = 32'hbb67ae85;
            3'd2: r = 32'h3c6ef372;
            3'd3: r = 32'ha54ff53a;
            3'd4: r = 32'h510e527f;
            3'd5: r = 32'h9b05688c;
            3'd6: r = 32'h1f83d9ab;
            default: r = 32'h5be0cd19;
        endcase
        return r;
    endfunction

    function automatic word_t round_k(input logic [5:0] idx);
        word_t r;
        case (idx)
            6'd0:  r = 32'h428a2f98; 6'd1:  r = 32'h71374491;
            6'd2:  r = 32'hb5c0fbcf; 6'd3:  r = 32'he9b5dba5;
            6'd4:  r = 32'h3956c25b; 6'd5:  r = 32'h59f111f1;
            6'd6:  r = 32'h923f82a4; 6'd7:  r = 32'hab1c5ed5;
            6'd8:  r = 32'hd807aa98; 6'd9:  r = 32'h12835b01;
            6'd10: r = 32'h243185be; 6'd11: r = 32'h550c7dc3;
            6'd12: r = 32'h72be5d74; 6'd13: r = 32'h80deb1fe;
            6'd14: r = 32'h9bdc06a7; 6'd15: r = 32'hc19bf174;
            6'd16: r = 32'he49b69c1; 6'd17: r = 32'hefbe4786;
            6'd18: r = 32'h0fc19dc6; 6'd19: r = 32'h240ca1cc;
            6'd20: r = 32'h2de92c6f; 6'd21: r = 32'h4a7484aa;
            6'd22: r = 32'h5cb0a9dc; 6'd23: r = 32'h76f988da;
            6'd24: r = 32'h983e5152; 6'd25: r = 32'ha831c66d;
            6'd26: r = 32'hb00327c8; 6'd27: r = 32'hbf597fc7;
            6'd28: r = 32'hc6e00bf3; 6'd29: r = 32'hd5a79147;
            6'd30: r = 32'h06ca6351; 6'd31: r = 32'h14292967;
            6'd32: r = 32'h27b70a85; 6'd33: r = 32'h2e1b2138;
            6'd34: r = 32'h4d2c6dfc; 6'd35: r = 32'h53380d13;
            6'd36: r = 32'h650a7354; 6'd37: r = 32'h766a0abb;
            6'd38: r = 32'h81c2c92e; 6'd39: r = 32'h92722c85;
            6'd40: r = 32'ha2bfe8a1; 6'd41: r = 32'ha81a664b;
            6'd42: r = 32'hc24b8b70; 6'd43: r = 32'hc76c51a3;
            6'd44: r = 32'hd192e819; 6'd45: r = 32'hd6990624;
            6'd46: r = 32'hf40e3585; 6'd47: r = 32'h106aa070;
            6'd48: r = 32'h19a4c116; 6'd49: r = 32'h1e376c08;
            6'd50: r = 32'h2748774c; 6'd51: r = 32'h34b0bcb5;
            6'd52: r = 32'h391c0cb3; 6'd53: r = 32'h4ed8aa4a;
            6'd54: r = 32'h5b9cca4f; 6'd55: r = 32'h682e6ff3;
            6'd56: r = 32'h748f82ee; 6'd57: r = 32'h78a5636f;
            6'd58: r = 32'h84c87814; 6'd59: r = 32'h8cc70208;
            6'd60: r = 32'h90befffa; 6'd61: r = 32'ha4506ceb;
            6'd62: r = 32'hbef9a3f7; default: r = 32'hc67178f2;
        endcase
        return r;
    endfunction

    function automatic word_t rotr(input word_t x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

endpackage

// ----- design/sha_buf.sv -----
// ----------------------------------------------------------------------------
// sha_buf
// block buffer: sixteen 32-bit words, one write and one registered read
// ----------------------------------------------------------------------------
module sha_buf (
    input  logic              clk,
    input  sha_pkg::buf_req_t req,
    output sha_pkg::word_t    rd_data
);

    sha_pkg::word_t mem [16];

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.wr_addr] <= req.wr_data;
        end
        rd_data <= mem[req.rd_addr];
    end

endmodule

// ----- design/sha_round.sv -----
// ----------------------------------------------------------------------------
// sha_round
// working variables and a 16-word message schedule window; while step is high, one round a cycle
// ----------------------------------------------------------------------------
module sha_round (
    input  logic           clk,
    input  logic           init,      // load working vars from hash
    input  logic           step,      // run one round
    input  logic           use_mem,   // w comes from buffer (rounds 0..15)
    input  logic [5:0]     round,
    input  sha_pkg::word_t mem_word,
    input  sha_pkg::word_t hash_in [8],
    output sha_pkg::word_t vars [8]
);

    sha_pkg::word_t v_reg [8];
    sha_pkg::word_t w_reg [16];
    sha_pkg::word_t w_new;
    sha_pkg::word_t w_cur;
    sha_pkg::word_t s0;
    sha_pkg::word_t s1;
    sha_pkg::word_t t1;
    sha_pkg::word_t t2;
    sha_pkg::word_t e;
    sha_pkg::word_t a;

    always_comb
    begin
        s0 = sha_pkg::rotr(w_reg[1], 7) ^ sha_pkg::rotr(w_reg[1], 18) ^ (w_reg[1] >> 3);
        s1 = sha_pkg::rotr(w_reg[14], 17) ^ sha_pkg::rotr(w_reg[14], 19)
            ^ (w_reg[14] >> 10);
        w_new = s1 + w_reg[9] + s0 + w_reg[0];
        w_cur = use_mem ? mem_word : w_new;
        e = v_reg[4];
        a = v_reg[0];
        t1 = v_reg[7] + (sha_pkg::rotr(e, 6) ^ sha_pkg::rotr(e, 11) ^ sha_pkg::rotr(e, 25))
            + ((e & v_reg[5]) ^ (~e & v_reg[6])) + sha_pkg::round_k(round) + w_cur;
        t2 = (sha_pkg::rotr(a, 2) ^ sha_pkg::rotr(a, 13) ^ sha_pkg::rotr(a, 22))
            + ((a & v_reg[1]) ^ (a & v_reg[2]) ^ (v_reg[1] & v_reg[2]));
    end

    always_ff @(posedge clk)
    begin
        if (init)
        begin
            for (int i = 0; i < 8; i++)
            begin
                v_reg[i] <= hash_in[i];
            end
        end
        else if (step)
        begin
            v_reg[7] <= v_reg[6];
            v_reg[6] <= v_reg[5];
            v_reg[5] <= v_reg[4];
            v_reg[4] <= v_reg[3] + t1;
            v_reg[3] <= v_reg[2];
            v_reg[2] <= v_reg[1];
            v_reg[1] <= v_reg[0];
            v_reg[0] <= t1 + t2;
            // window holds w[i-16..i-1]
            for (int i = 0; i < 15; i++)
            begin
                w_reg[i] <= w_reg[i + 1];
            end
            w_reg[15] <= w_cur;
        end
    end

    assign vars = v_reg;

endmodule

// ----- design/sha256_digest_engine.sv -----
// ----------------------------------------------------------------------------
// sha256_digest_engine
// byte-wide sha-256 hasher with padding and word-serial digest output
// ----------------------------------------------------------------------------
// An item with a byte absorbs it into the block buffer. The item that fills a
// 64-byte block, and every end item, starts the compression: a load step, 64
// rounds (of a single round unit; message words of rounds 0..15 come from the
// 16-word buffer memory, later ones from the schedule window) and an add into
// the hash. No item is taken while a block is being compressed.
// An end item also writes the padding words of each padding block, may need
// two compressions, and then gives eight digest items, word 0 first.
module sha256_digest_engine (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        valid_in,
    output logic        ready_in,
    input  logic [7:0]  msg_byte,
    input  logic        byte_present,
    input  logic        msg_end,
    output logic        valid_out,
    input  logic        ready_out,
    output logic [31:0] digest_word,
    output logic [2:0]  word_index,
    output logic        last_word
);

    sha_pkg::state_t  state_reg, state_next;
    sha_pkg::word_t   hash_reg [8];
    sha_pkg::word_t   acc_reg;          // partial word being filled
    logic [5:0]       fill_reg;
    logic [63:0]      len_reg;
    logic [5:0]       round_reg;
    logic [3:0]       pad_reg;          // padding word address
    logic             second_reg;       // padding needs a further block
    logic             ending_reg;       // compression belongs to the end item
    logic             full_reg;         // compression came from a full block
    logic [2:0]       out_reg;

    sha_pkg::buf_req_t req;
    sha_pkg::word_t    mem_word;
    sha_pkg::word_t    vars [8];
    logic              accept;
    logic              init;
    logic              step;

    sha_buf u_buf (
        .clk     (clk),
        .req     (req),
        .rd_data (mem_word)
    );

    sha_round u_round (
        .clk      (clk),
        .init     (init),
        .step     (step),
        .use_mem  (round_reg < 6'd16),
        .round    (round_reg),
        .mem_word (mem_word),
        .hash_in  (hash_reg),
        .vars     (vars)
    );

    assign accept = valid_in && ready_in;

    // byte-level view of the item's effect
    logic [5:0]     new_fill;
    sha_pkg::word_t new_acc;
    always_comb
    begin
        new_acc = acc_reg;
        case (fill_reg[1:0])
            2'd0: new_acc = {msg_byte, 24'h0};
            2'd1: new_acc[23:16] = msg_byte;
            2'd2: new_acc[15:8] = msg_byte;
            default: new_acc[7:0] = msg_byte;
        endcase
        new_fill = fill_reg + 6'd1;
    end

    // padding word at pad_reg, with fill_reg bytes of message in the block
    sha_pkg::word_t pad_word;
    logic [3:0]     fill_word;
    always_comb
    begin
        fill_word = fill_reg[5:2];
        pad_word = 32'h0;
        if (second_reg)
        begin
            pad_word = 32'h0;
        end
        else if (pad_reg == fill_word)
        begin
            case (fill_reg[1:0])
                2'd0: pad_word = {sha_pkg::PAD_BYTE, 24'h0};
                2'd1: pad_word = {acc_reg[31:24], sha_pkg::PAD_BYTE, 16'h0};
                2'd2: pad_word = {acc_reg[31:16], sha_pkg::PAD_BYTE, 8'h0};
                default: pad_word = {acc_reg[31:8], sha_pkg::PAD_BYTE};
            endcase
        end
        if ((second_reg || fill_reg < 6'd56) && pad_reg == 4'd14)
        begin
            pad_word = len_reg[63:32];
        end
        if ((second_reg || fill_reg < 6'd56) && pad_reg == 4'd15)
        begin
            pad_word = len_reg[31:0];
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            sha_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    if (byte_present && fill_reg == 6'd63)
                    begin
                        state_next = sha_pkg::ST_LOAD;
                    end
                    else if (msg_end)
                    begin
                        state_next = sha_pkg::ST_PAD;
                    end
                end
            end
            sha_pkg::ST_PAD:
            begin
                if (pad_reg == 4'd15)
                begin
                    state_next = sha_pkg::ST_LOAD;
                end
            end
            sha_pkg::ST_LOAD:  state_next = sha_pkg::ST_ROUND;
            sha_pkg::ST_ROUND:
            begin
                if (round_reg == 6'd63)
                begin
                    state_next = sha_pkg::ST_FINAL;
                end
            end
            sha_pkg::ST_FINAL:
            begin
                if (!ending_reg)
                begin
                    state_next = sha_pkg::ST_IDLE;
                end
                else if (full_reg || (fill_reg >= 6'd56 && !second_reg))
                begin
                    state_next = sha_pkg::ST_PAD;
                end
                else
                begin
                    state_next = sha_pkg::ST_OUT;
                end
            end
            sha_pkg::ST_OUT:
            begin
                if (ready_out && out_reg == 3'd7)
                begin
                    state_next = sha_pkg::ST_IDLE;
                end
            end
            default: state_next = sha_pkg::ST_IDLE;
        endcase
    end

    // buffer access and round control
    always_comb
    begin
        ready_in = (state_reg == sha_pkg::ST_IDLE);
        valid_out = (state_reg == sha_pkg::ST_OUT);
        init = (state_reg == sha_pkg::ST_LOAD);
        step = (state_reg == sha_pkg::ST_ROUND);
        req.wr_en = 1'b0;
        req.wr_addr = fill_reg[5:2];
        req.wr_data = new_acc;
        // read one ahead of the round that uses it
        req.rd_addr = (state_reg == sha_pkg::ST_LOAD) ? 4'd0 : round_reg[3:0] + 4'd1;
        case (state_reg)
            sha_pkg::ST_IDLE:
            begin
                req.wr_en = accept && byte_present && fill_reg[1:0] == 2'd3;
            end
            sha_pkg::ST_PAD:
            begin
                req.wr_addr = pad_reg;
                req.wr_data = pad_word;
                // message words below the partial one stay as written
                req.wr_en = second_reg || pad_reg >= fill_word;
            end
            default: req.wr_en = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sha_pkg::ST_IDLE;
            fill_reg <= 6'd0;
            len_reg <= 64'd0;
            round_reg <= 6'd0;
            pad_reg <= 4'd0;
            second_reg <= 1'b0;
            ending_reg <= 1'b0;
            full_reg <= 1'b0;
            out_reg <= 3'd0;
            for (int i = 0; i < 8; i++)
            begin
                hash_reg[i] <= sha_pkg::init_hash(3'(i));
            end
        end
        else
        begin
            state_reg <= state_next;
            case (state_reg)
                sha_pkg::ST_IDLE:
                begin
                    if (accept)
                    begin
                        pad_reg <= 4'd0;
                        second_reg <= 1'b0;
                        ending_reg <= msg_end;
                        full_reg <= byte_present && fill_reg == 6'd63;
                        if (byte_present)
                        begin
                            fill_reg <= new_fill;
                            len_reg <= len_reg + 64'd8;
                        end
                    end
                end
                sha_pkg::ST_PAD:  pad_reg <= pad_reg + 4'd1;
                sha_pkg::ST_LOAD: round_reg <= 6'd0;
                sha_pkg::ST_ROUND: round_reg <= round_reg + 6'd1;
                sha_pkg::ST_FINAL:
                begin
                    for (int i = 0; i < 8; i++)
                    begin
                        hash_reg[i] <= hash_reg[i] + vars[i];
                    end
                    if (ending_reg && fill_reg >= 6'd56 && !second_reg)
                    begin
                        second_reg <= 1'b1;
                        pad_reg <= 4'd0;
                    end
                    full_reg <= 1'b0;
                    out_reg <= 3'd0;
                end
                sha_pkg::ST_OUT:
                begin
                    if (ready_out)
                    begin
                        out_reg <= out_reg + 3'd1;
                        if (out_reg == 3'd7)
                        begin
                            fill_reg <= 6'd0;
                            len_reg <= 64'd0;
                            ending_reg <= 1'b0;
                            for (int i = 0; i < 8; i++)
                            begin
                                hash_reg[i] <= sha_pkg::init_hash(3'(i));
                            end
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && byte_present)
        begin
            acc_reg <= new_acc;
        end
    end

    assign digest_word = hash_reg[out_reg];
    assign word_index = out_reg;
    assign last_word = (out_reg == 3'd7);

endmodule
